@@ rtl/compass_sobel_edge_magnitude_unit_assert.svh @@
// assertion macros for the compass sobel edge magnitude unit checker
// expects signals named clk and rst in the scope where a macro is used
`ifndef COMPASS_SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH
`define COMPASS_SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is high
`define CSEM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define CSEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define CSEM_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/csem_pkg.sv @@
// shared types, constants and kernel math for the compass sobel edge unit
// no dependencies
`timescale 1ns / 1ps

package csem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // register field width and counter widths
  localparam int DIM_W    = 11;
  localparam int CNT_W    = DIM_W + 1;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);
  localparam int OROW_W   = $clog2(MAX_HEIGHT);
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W    = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // input beat kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
  localparam logic [DIM_W-1:0] LIMIT_WIDTH  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] LIMIT_HEIGHT = DIM_W'(MAX_HEIGHT);

  // horizontal, vertical and the two diagonal kernels, row major
  localparam logic signed [2:0] KERNEL [4][9] = '{
    '{ 3'sd1,  3'sd0, -3'sd1,  3'sd2,  3'sd0, -3'sd2,  3'sd1,  3'sd0, -3'sd1},
    '{ 3'sd1,  3'sd2,  3'sd1,  3'sd0,  3'sd0,  3'sd0, -3'sd1, -3'sd2, -3'sd1},
    '{-3'sd2, -3'sd1,  3'sd0, -3'sd1,  3'sd0,  3'sd1,  3'sd0,  3'sd1,  3'sd2},
    '{ 3'sd0, -3'sd1, -3'sd2,  3'sd1,  3'sd0, -3'sd1,  3'sd2,  3'sd1,  3'sd0}
  };

  // 3x3 neighborhood, entry 3*row+column, column 2 newest
  typedef logic [8:0][PIX_W-1:0] win_t;

  // one item on its way from the accept stage to the filter stage
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             mtop;
    logic             mbot;
    logic             mleft;
    logic             mright;
    logic             last;
  } item_t;

  // register value of zero acts as one, above the limit acts as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                 input logic [DIM_W-1:0] limit);
    logic [DIM_W-1:0] res;
    res = value;
    if (value == '0) res = DIM_W'(1);
    else if (value > limit) res = limit;
    return res;
  endfunction

  // four clamped kernel responses, summed with saturation
  function automatic logic [PIX_W-1:0] edge_sum(input win_t win);
    logic signed [11:0] acc;
    logic signed [11:0] coef;
    logic [PIX_W-1:0]   clamped;
    logic [9:0]         total;
    total = '0;
    for (int k = 0; k < 4; k++) begin
      acc = '0;
      for (int i = 0; i < 9; i++) begin
        coef = 12'(KERNEL[k][i]);
        acc  = acc + $signed({4'b0, win[i]}) * coef;
      end
      if (acc[11]) clamped = '0;
      else if (acc > 12'sd255) clamped = 8'hff;
      else clamped = acc[7:0];
      total = total + {2'b0, clamped};
    end
    return (total > 10'd255) ? 8'hff : total[7:0];
  endfunction

endpackage

@@ rtl/compass_sobel_edge_magnitude_unit.sv @@
// top level of the four-direction sobel edge magnitude unit
// depends on csem_pkg, csem_ctrl, csem_linebuf, csem_filter
`timescale 1ns / 1ps

// Streams 8-bit grey pixels in raster order and returns one edge magnitude
// per pixel: the sum of four clamped 3x3 kernel responses (horizontal,
// vertical, both diagonals), saturated at 255, with out-of-frame neighbors
// taken as zero. Results trail the input by one row plus one pixel, so after
// the last pixel of a frame send flush beats (op = 1) until the beat marked
// last comes out; later flushes are dropped and the next pixel starts a new
// frame. The unit takes one beat per clock unless a stalled result holds it
// back. An accepted beat reads the line buffer ram and loads the item register;
// when the filter stage moves on, the kernel sum goes into the result register.
// The line buffer is a single ram with one read and one write port, each used
// once per beat that is not dropped.
// Writing frame_width or frame_height restarts the frame; a value of zero
// acts as one and a value above 1024 acts as 1024. Write them only when idle.
module compass_sobel_edge_magnitude_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic [csem_pkg::PIX_W-1:0]     pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [csem_pkg::PIX_W-1:0]     edge_res,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [csem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csem_pkg::DIM_W-1:0]     cfg_data
);

  logic                               s1_valid;
  logic                               s1_go;
  csem_pkg::item_t                    s1_item;
  logic                               rd_en;
  logic [csem_pkg::COL_W-1:0]         rd_addr;
  logic [2*csem_pkg::PIX_W-1:0]       rd_data;
  logic                               wr_en;
  logic [csem_pkg::COL_W-1:0]         wr_addr;
  logic [2*csem_pkg::PIX_W-1:0]       wr_data;

  // accept stage
  csem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .pixel     (pixel),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s1_go     (s1_go),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  // row buffers
  csem_linebuf u_linebuf (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // window and kernel stage
  csem_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_go     (s1_go),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .edge_res  (edge_res),
    .last      (last)
  );

endmodule

@@ rtl/csem_linebuf.sv @@
// two stacked row buffers in one ram, entry = {row above previous, previous row}
// depends on csem_pkg
`timescale 1ns / 1ps

module csem_linebuf (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [csem_pkg::COL_W-1:0] rd_addr,
  output logic [2*csem_pkg::PIX_W-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [csem_pkg::COL_W-1:0] wr_addr,
  input  logic [2*csem_pkg::PIX_W-1:0] wr_data
);

  logic [2*csem_pkg::PIX_W-1:0] mem [csem_pkg::MAX_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, new data passed through on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

@@ rtl/csem_ctrl.sv @@
// accept stage: frame registers, raster counters, flush handling, item register
// depends on csem_pkg
`timescale 1ns / 1ps

module csem_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [csem_pkg::PIX_W-1:0]    pixel,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csem_pkg::DIM_W-1:0]    cfg_data,
  input  logic                          s1_go,
  output logic                          s1_valid,
  output csem_pkg::item_t               s1_item,
  output logic                          rd_en,
  output logic [csem_pkg::COL_W-1:0]    rd_addr
);

  localparam int CNT_W = csem_pkg::CNT_W;

  logic [csem_pkg::DIM_W-1:0]  frame_width;
  logic [csem_pkg::DIM_W-1:0]  frame_height;
  logic [csem_pkg::COL_W-1:0]  in_column, in_column_next;
  logic [csem_pkg::ROW_W-1:0]  in_row, in_row_next;
  logic [csem_pkg::COL_W-1:0]  out_column, out_column_next;
  logic [csem_pkg::OROW_W-1:0] out_row, out_row_next;
  logic                        frame_done, frame_done_next;

  logic                        accept, drop;
  logic [csem_pkg::COL_W-1:0]  cur_in_col, cur_out_col;
  logic [csem_pkg::ROW_W-1:0]  cur_in_row;
  logic [csem_pkg::OROW_W-1:0] cur_out_row;
  logic [CNT_W-1:0]            in_col_inc, out_col_inc;
  csem_pkg::item_t             item_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid || s1_go;
  assign accept    = in_valid && in_ready;
  // flush after the final result is swallowed
  assign drop      = frame_done && (op == csem_pkg::OP_FLUSH);

  // a pixel after the frame's final result starts from the origin
  assign cur_in_col  = frame_done ? '0 : in_column;
  assign cur_in_row  = frame_done ? '0 : in_row;
  assign cur_out_col = frame_done ? '0 : out_column;
  assign cur_out_row = frame_done ? '0 : out_row;

  assign rd_en   = accept && !drop;
  assign rd_addr = cur_in_col;

  // item fields and next counter values
  always_comb begin
    item_next.pixel = ((op == csem_pkg::OP_PIXEL) &&
                       (CNT_W'(cur_in_row) < CNT_W'(frame_height))) ? pixel : '0;
    item_next.col   = cur_in_col;
    item_next.emit  = (cur_in_row >= csem_pkg::ROW_W'(2)) ||
                      ((cur_in_row == csem_pkg::ROW_W'(1)) && (cur_in_col != '0));
    item_next.mtop   = (cur_out_row == '0);
    item_next.mbot   = (CNT_W'(cur_out_row) == (CNT_W'(frame_height) - CNT_W'(1)));
    item_next.mleft  = (cur_out_col == '0);
    item_next.mright = (CNT_W'(cur_out_col) == (CNT_W'(frame_width) - CNT_W'(1)));
    item_next.last   = item_next.mbot && item_next.mright;

    // input position
    in_col_inc = CNT_W'(cur_in_col) + CNT_W'(1);
    if (in_col_inc >= CNT_W'(frame_width)) begin
      in_column_next = '0;
      in_row_next    = cur_in_row + csem_pkg::ROW_W'(1);
    end else begin
      in_column_next = in_col_inc[csem_pkg::COL_W-1:0];
      in_row_next    = cur_in_row;
    end

    // output position
    out_col_inc     = CNT_W'(cur_out_col) + CNT_W'(1);
    out_column_next = cur_out_col;
    out_row_next    = cur_out_row;
    frame_done_next = 1'b0;
    if (item_next.emit) begin
      if (item_next.last) begin
        in_column_next  = '0;
        in_row_next     = '0;
        out_column_next = '0;
        out_row_next    = '0;
        frame_done_next = 1'b1;
      end else if (out_col_inc >= CNT_W'(frame_width)) begin
        out_column_next = '0;
        out_row_next    = cur_out_row + csem_pkg::OROW_W'(1);
      end else begin
        out_column_next = out_col_inc[csem_pkg::COL_W-1:0];
      end
    end
  end

  // frame registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= csem_pkg::RESET_WIDTH;
      frame_height <= csem_pkg::RESET_HEIGHT;
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
      frame_done   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csem_pkg::REG_FRAME_WIDTH: begin
          frame_width <= csem_pkg::clamp_dim(cfg_data, csem_pkg::LIMIT_WIDTH);
        end
        csem_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= csem_pkg::clamp_dim(cfg_data, csem_pkg::LIMIT_HEIGHT);
        end
        default: begin
        end
      endcase
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      frame_done <= 1'b0;
    end else if (accept && !drop) begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      frame_done <= frame_done_next;
    end
  end

  // item register toward the filter stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= !drop;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item_next;
    end
  end

endmodule

@@ rtl/csem_filter.sv @@
// filter stage: 3x3 window shift, edge masking, kernel sum and result register
// depends on csem_pkg
`timescale 1ns / 1ps

module csem_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s1_valid,
  input  csem_pkg::item_t               s1_item,
  output logic                          s1_go,
  input  logic [2*csem_pkg::PIX_W-1:0]  rd_data,
  output logic                          wr_en,
  output logic [csem_pkg::COL_W-1:0]    wr_addr,
  output logic [2*csem_pkg::PIX_W-1:0]  wr_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csem_pkg::PIX_W-1:0]    edge_res,
  output logic                          last
);

  csem_pkg::win_t        window, window_next, window_masked;
  logic [csem_pkg::PIX_W-1:0] top, mid;

  assign top = rd_data[2*csem_pkg::PIX_W-1:csem_pkg::PIX_W];
  assign mid = rd_data[csem_pkg::PIX_W-1:0];

  // stage moves on unless its result would overwrite a waiting beat
  assign s1_go = s1_valid && (!s1_item.emit || !out_valid || out_ready);

  // rows shift down one place in the buffers
  assign wr_en   = s1_go;
  assign wr_addr = s1_item.col;
  assign wr_data = {mid, s1_item.pixel};

  // shift in the new column, zero the neighbors outside the frame
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_next[3*r]   = window[3*r+1];
      window_next[3*r+1] = window[3*r+2];
    end
    window_next[2] = top;
    window_next[5] = mid;
    window_next[8] = s1_item.pixel;
    for (int i = 0; i < 9; i++) begin
      if ((i < 3 && s1_item.mtop) || (i >= 6 && s1_item.mbot) ||
          (i % 3 == 0 && s1_item.mleft) || (i % 3 == 2 && s1_item.mright)) begin
        window_masked[i] = '0;
      end else begin
        window_masked[i] = window_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      window <= window_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_item.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item.emit) begin
      edge_res <= csem_pkg::edge_sum(window_masked);
      last     <= s1_item.last;
    end
  end

endmodule

@@ rtl/csem_checker.sv @@
// port-level checks for the sobel edge magnitude unit, bound to the top level
// depends on compass_sobel_edge_magnitude_unit_assert.svh and csem_pkg
`timescale 1ns / 1ps
`include "compass_sobel_edge_magnitude_unit_assert.svh"

module csem_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [csem_pkg::PIX_W-1:0] edge_res,
  input logic                       last
);

  // a waiting result beat holds its payload
  `CSEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(edge_res) && $stable(last), "result beat changed while stalled")

  // reset empties the result register
  `CSEM_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid, "result valid right after reset")

  // with no result pending nothing can hold the input back
  `CSEM_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

  // a fresh result follows an accepted input beat
  `CSEM_ASSERT_NOW(a_result_cause, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a causing input beat")

endmodule

bind compass_sobel_edge_magnitude_unit csem_checker u_csem_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .edge_res  (edge_res),
  .last      (last)
);

@@ sim/compass_sobel_edge_magnitude_unit_tb.sv @@
// self-checking testbench for the four-direction sobel edge magnitude unit
// depends on csem_pkg and compass_sobel_edge_magnitude_unit
`timescale 1ns / 1ps

module compass_sobel_edge_magnitude_unit_tb;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 780;

  // horizontal, vertical, falling and rising diagonal, row major
  localparam int SOBEL_K [4][9] = '{
    '{ 1,  0, -1,  2,  0, -2,  1,  0, -1},
    '{ 1,  2,  1,  0,  0,  0, -1, -2, -1},
    '{-2, -1,  0, -1,  0,  1,  0,  1,  2},
    '{ 0, -1, -2,  1,  0, -1,  2,  1,  0}
  };

  typedef enum int {PAT_NOISE, PAT_BINARY, PAT_RAMP, PAT_SPOTS, PAT_FLAT} pattern_t;

  typedef struct {
    logic                       op;
    logic [csem_pkg::PIX_W-1:0] pixel;
    bit                         hold;
  } px_beat_t;

  typedef struct {
    logic [csem_pkg::PIX_W-1:0] mag;
    logic                       last;
  } edge_beat_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           op = csem_pkg::OP_PIXEL;
  logic [csem_pkg::PIX_W-1:0]     pixel = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [csem_pkg::PIX_W-1:0]     edge_res;
  logic                           last;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [csem_pkg::CFG_IDX_W-1:0] cfg_index = csem_pkg::REG_FRAME_WIDTH;
  logic [csem_pkg::DIM_W-1:0]     cfg_data = '0;

  px_beat_t   pending[$];
  edge_beat_t mag_expect[$];
  int mismatches = 0;
  int stuck_cycles = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_gap = 0;
  int recv_calm = 0;
  int rand_items = 0;

  // predictor state
  logic [csem_pkg::PIX_W-1:0] row_up1 [csem_pkg::MAX_WIDTH];
  logic [csem_pkg::PIX_W-1:0] row_up2 [csem_pkg::MAX_WIDTH];
  logic [csem_pkg::PIX_W-1:0] win [9];
  int eff_w, eff_h;
  int in_x, in_y, out_x, out_y;
  bit frame_closed;

  compass_sobel_edge_magnitude_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .edge_res  (edge_res),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // frame position restart, line data is kept
  function automatic void restart_frame();
    in_x = 0;
    in_y = 0;
    out_x = 0;
    out_y = 0;
    frame_closed = 1'b0;
  endfunction

  function automatic void predictor_reset();
    foreach (row_up1[i]) begin
      row_up1[i] = '0;
      row_up2[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    eff_w = 640;
    eff_h = 480;
    restart_frame();
  endfunction

  // zero acts as one, above the limit acts as the limit
  function automatic int legal_dim(input logic [csem_pkg::DIM_W-1:0] v, input int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  function automatic void apply_dim(input logic [csem_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [csem_pkg::DIM_W-1:0] v);
    if (idx == csem_pkg::REG_FRAME_WIDTH) eff_w = legal_dim(v, csem_pkg::MAX_WIDTH);
    else eff_h = legal_dim(v, csem_pkg::MAX_HEIGHT);
    restart_frame();
  endfunction

  // advance the edge predictor by one accepted beat, queue its result if any
  function automatic void sobel_step(input logic is_flush,
                                     input logic [csem_pkg::PIX_W-1:0] px);
    logic [csem_pkg::PIX_W-1:0] v, up1, up2;
    int acc, total;
    bit fire, at_end;
    edge_beat_t beat;
    if (frame_closed) begin
      if (is_flush) return;
      restart_frame();
    end
    v = (!is_flush && in_y < eff_h) ? px : '0;
    up2 = row_up2[in_x];
    up1 = row_up1[in_x];
    row_up2[in_x] = up1;
    row_up1[in_x] = v;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = v;
    fire = (in_y >= 2) || (in_y == 1 && in_x >= 1);
    in_x++;
    if (in_x >= eff_w) begin
      in_x = 0;
      in_y++;
    end
    if (!fire) return;
    // out-of-frame neighbors contribute nothing
    total = 0;
    for (int k = 0; k < 4; k++) begin
      acc = 0;
      for (int r = 0; r < 3; r++) begin
        if ((r == 0 && out_y == 0) || (r == 2 && out_y == eff_h - 1)) continue;
        for (int c = 0; c < 3; c++) begin
          if ((c == 0 && out_x == 0) || (c == 2 && out_x == eff_w - 1)) continue;
          acc += int'(win[r*3+c]) * SOBEL_K[k][r*3+c];
        end
      end
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      total += acc;
    end
    if (total > 255) total = 255;
    at_end = (out_y == eff_h - 1) && (out_x == eff_w - 1);
    beat.mag = csem_pkg::PIX_W'(total);
    beat.last = at_end;
    mag_expect = {mag_expect, beat};
    if (at_end) begin
      restart_frame();
      frame_closed = 1'b1;
    end else begin
      out_x++;
      if (out_x >= eff_w) begin
        out_x = 0;
        out_y++;
      end
    end
  endfunction

  // idle length: mostly none, some short, a few long, with calm stretches
  function automatic int draw_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(999);
    if (roll < 5) begin
      calm = $urandom_range(300, 50);
      return 0;
    end
    if (roll < 600) return 0;
    if (roll < 900) return $urandom_range(3, 1);
    if (roll < 980) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [csem_pkg::PIX_W-1:0] pattern_pixel(input pattern_t pat,
                                                               input int r, input int c,
                                                               input int base);
    case (pat)
      PAT_BINARY: return $urandom_range(1) ? 8'hff : 8'h00;
      PAT_RAMP:   return csem_pkg::PIX_W'(base + r * 37 + c * 23);
      PAT_SPOTS:  return ($urandom_range(7) == 0) ? csem_pkg::PIX_W'($urandom_range(255))
                                                  : 8'h00;
      PAT_FLAT:   return csem_pkg::PIX_W'(base + $urandom_range(3));
      default:    return csem_pkg::PIX_W'($urandom_range(255));
    endcase
  endfunction

  // input beat driver
  always @(posedge clk) begin : drive_pixels
    bit nxt_valid;
    px_beat_t it;
    nxt_valid = in_valid;
    if (!rst) begin
      if (in_valid && in_ready) begin
        sobel_step(op, pixel);
        nxt_valid = 1'b0;
        send_gap = draw_gap(send_calm);
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending.size() != 0 &&
                     !(pending[0].hold && mag_expect.size() != 0)) begin
          it = pending.pop_front();
          op <= it.op;
          pixel <= it.pixel;
          nxt_valid = 1'b1;
        end
      end
    end
    in_valid <= nxt_valid;
  end

  // result monitor and output backpressure
  always @(posedge clk) begin : check_results
    edge_beat_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (mag_expect.size() == 0) begin
          $error("result beat with nothing expected: edge_res %0d last %0d",
                 edge_res, last);
          mismatches++;
        end else begin
          want = mag_expect.pop_front();
          if (edge_res !== want.mag) begin
            $error("edge_res mismatch: expected %0d, actual %0d", want.mag, edge_res);
            mismatches++;
          end
          if (last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, last);
            mismatches++;
          end
        end
      end
      if (recv_gap == 0 && ((out_valid && out_ready) || $urandom_range(7) == 0))
        recv_gap = draw_gap(recv_calm);
    end
    if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // wait until every queued beat is sent and every result has come back
  task automatic settle();
    while (pending.size() != 0 || in_valid || mag_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [csem_pkg::CFG_IDX_W-1:0] idx,
                           input logic [csem_pkg::DIM_W-1:0] v);
    settle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    apply_dim(idx, v);
  endtask

  function automatic void queue_beat(input logic is_flush,
                                     input logic [csem_pkg::PIX_W-1:0] v,
                                     input bit hold);
    px_beat_t it;
    it.op = is_flush;
    it.pixel = v;
    it.hold = hold;
    pending = {pending, it};
  endfunction

  // one frame of pixels plus the flushes that push out its last result, or a prefix of it when truncated;
  // noisy frames swap some ops without moving the frame end
  function automatic void queue_frame(input pattern_t pat, input bit noisy,
                                      input bit truncate, input bit counted);
    int total, cut, base;
    logic is_flush;
    logic [csem_pkg::PIX_W-1:0] v;
    total = eff_w * eff_h + eff_w + 1;
    cut = truncate ? $urandom_range(total - 1, 1) : total;
    base = $urandom_range(255);
    for (int n = 0; n < cut; n++) begin
      is_flush = (n >= eff_w * eff_h) ? csem_pkg::OP_FLUSH : csem_pkg::OP_PIXEL;
      v = (is_flush == csem_pkg::OP_FLUSH) ? csem_pkg::PIX_W'($urandom_range(255))
                                           : pattern_pixel(pat, n / eff_w, n % eff_w, base);
      if (noisy && $urandom_range(9) == 0) is_flush = !is_flush;
      queue_beat(is_flush, v, $urandom_range(199) == 0);
      if (counted) rand_items++;
    end
    // flushes after the last result are dropped by the unit
    if (!truncate && $urandom_range(3) == 0)
      repeat ($urandom_range(3, 1))
        queue_beat(csem_pkg::OP_FLUSH, csem_pkg::PIX_W'($urandom_range(255)), 1'b0);
  endfunction

  initial begin : stimulus
    int sel, wv, hv;
    predictor_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: 3x2 frames, extreme levels, misplaced ops
    write_reg(csem_pkg::REG_FRAME_WIDTH, csem_pkg::DIM_W'(3));
    write_reg(csem_pkg::REG_FRAME_HEIGHT, csem_pkg::DIM_W'(2));
    queue_beat(csem_pkg::OP_PIXEL, 8'hff, 1'b0);
    queue_beat(csem_pkg::OP_PIXEL, 8'h00, 1'b0);
    queue_beat(csem_pkg::OP_PIXEL, 8'hff, 1'b0);
    queue_beat(csem_pkg::OP_PIXEL, 8'h00, 1'b0);
    queue_beat(csem_pkg::OP_PIXEL, 8'hff, 1'b0);
    queue_beat(csem_pkg::OP_PIXEL, 8'h00, 1'b0);
    repeat (4) queue_beat(csem_pkg::OP_FLUSH, 8'h00, 1'b0);
    queue_beat(csem_pkg::OP_FLUSH, 8'hff, 1'b0);
    queue_beat(csem_pkg::OP_PIXEL, 8'h00, 1'b0);
    queue_beat(csem_pkg::OP_PIXEL, 8'hff, 1'b0);
    // flush inside the frame stands for a black pixel
    queue_beat(csem_pkg::OP_FLUSH, 8'hff, 1'b0);
    queue_beat(csem_pkg::OP_PIXEL, 8'hff, 1'b0);
    queue_beat(csem_pkg::OP_PIXEL, 8'h80, 1'b0);
    // sender holds here until the results so far are drained
    queue_beat(csem_pkg::OP_PIXEL, 8'h01, 1'b1);
    queue_beat(csem_pkg::OP_FLUSH, 8'h00, 1'b0);
    // pixel after the frame end counts as a flush
    queue_beat(csem_pkg::OP_PIXEL, 8'hc8, 1'b0);
    queue_beat(csem_pkg::OP_FLUSH, 8'h00, 1'b0);
    queue_beat(csem_pkg::OP_FLUSH, 8'h00, 1'b0);

    // wide rows, height written as zero
    write_reg(csem_pkg::REG_FRAME_WIDTH, csem_pkg::DIM_W'(100));
    write_reg(csem_pkg::REG_FRAME_HEIGHT, csem_pkg::DIM_W'(0));
    queue_frame(PAT_NOISE, 1'b0, 1'b0, 1'b0);
    // single column, width written as zero
    write_reg(csem_pkg::REG_FRAME_WIDTH, csem_pkg::DIM_W'(0));
    write_reg(csem_pkg::REG_FRAME_HEIGHT, csem_pkg::DIM_W'(150));
    queue_frame(PAT_BINARY, 1'b0, 1'b0, 1'b0);

    // random phases, mostly small frames
    while (rand_items < RANDOM_ITEMS) begin
      sel = $urandom_range(9);
      if (sel < 6) begin
        wv = $urandom_range(12, 1);
        hv = $urandom_range(8, 1);
      end else if (sel < 8) begin
        wv = $urandom_range(40, 13);
        hv = $urandom_range(4, 1);
      end else if (sel == 8) begin
        wv = $urandom_range(4, 0);
        hv = $urandom_range(6, 0);
      end else begin
        wv = $urandom_range(6, 2);
        hv = $urandom_range(2047, 1025);
        if ($urandom_range(1)) hv = $urandom_range(3, 1);
      end
      if ($urandom_range(1)) begin
        write_reg(csem_pkg::REG_FRAME_HEIGHT, csem_pkg::DIM_W'(hv));
        write_reg(csem_pkg::REG_FRAME_WIDTH, csem_pkg::DIM_W'(wv));
      end else if ($urandom_range(3) != 0) begin
        write_reg(csem_pkg::REG_FRAME_WIDTH, csem_pkg::DIM_W'(wv));
        write_reg(csem_pkg::REG_FRAME_HEIGHT, csem_pkg::DIM_W'(hv));
      end else begin
        write_reg(csem_pkg::REG_FRAME_WIDTH, csem_pkg::DIM_W'(wv));
      end
      // keep tall frames rare
      if (eff_w * eff_h > 400)
        write_reg(csem_pkg::REG_FRAME_HEIGHT, csem_pkg::DIM_W'($urandom_range(4, 1)));
      repeat ($urandom_range(3, 1))
        queue_frame(pattern_t'($urandom_range(4)), $urandom_range(3) == 0, 1'b0, 1'b1);
      // cut a frame short so the next register write restarts it mid-way
      if ($urandom_range(3) == 0)
        queue_frame(pattern_t'($urandom_range(4)), 1'b0, 1'b1, 1'b1);
    end

    settle();
    if (mismatches == 0 && mag_expect.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
